// ===== rtl/core/opaque_element_table_walker_macros.svh =====
// Assertion macros for the opaque element table walker checks.
`ifndef OPAQUE_ELEMENT_TABLE_WALKER_MACROS_SVH
`define OPAQUE_ELEMENT_TABLE_WALKER_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define OETW_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("oetw check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define OETW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("oetw check failed");

`endif

// ===== rtl/core/oetw_pkg.sv =====
// Shared types and constants of the opaque element table walker.
`timescale 1ns / 1ps
package oetw_pkg;

   localparam int unsigned MAX_BLOB_BYTES = 1024;
   localparam int unsigned POS_W = $clog2(MAX_BLOB_BYTES + 1);
   localparam int unsigned OFF_W = 10;
   localparam int unsigned LEN_W = 11;
   localparam int unsigned CNT_W = 16;

   localparam logic [31:0] SPEC_ID_RESET = 32'h444D_5446;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_HEADER   = 3'd1,
      ERR_ID_RANGE = 3'd2,
      ERR_OVERRUN  = 3'd3,
      ERR_SIZE     = 3'd4,
      ERR_PADDING  = 3'd5,
      ERR_TOO_LONG = 3'd6,
      ERR_ALIGN    = 3'd7
   } err_type;

   typedef enum logic [2:0] {
      CSR_HEADER_MODE = 3'd0,
      CSR_SPEC_ID     = 3'd1,
      CSR_VERSION     = 3'd2,
      CSR_ID_LIMIT    = 3'd3,
      CSR_TARGET_ID   = 3'd4,
      CSR_TARGET_IDX  = 3'd5,
      CSR_STRICT_PAD  = 3'd6
   } csr_index_type;

   typedef enum logic [8:0] {
      PH_HDR    = 9'b000000001,
      PH_ID     = 9'b000000010,
      PH_VLEN   = 9'b000000100,
      PH_VENDOR = 9'b000001000,
      PH_DLEN0  = 9'b000010000,
      PH_DLEN1  = 9'b000100000,
      PH_DATA   = 9'b001000000,
      PH_PAD    = 9'b010000000,
      PH_END    = 9'b100000000
   } phase_type;

endpackage

// ===== rtl/core/opaque_element_table_walker.sv =====
// Top level of the opaque element table walker: byte parser and result register.
`timescale 1ns / 1ps
// Usage:
//   Request channel (req_valid / req_stall) carries one blob byte per request,
//   with req_last_byte set on the final byte. Each byte lands in an input
//   register and then updates the parse state; a last byte waits there while a response is held.
//   Response channel (rsp_valid / rsp_stall) carries one verdict per blob,
//   issued for the request flagged last; other requests give no response.
//   Configuration channel (csr_valid / csr_ready, csr_ready always high)
//   writes the checking registers by index; write only while no blob is open.
// Throughput: one request per cycle while req_stall is low, set by the
//   combinational parse state update between the input register and the state registers.
// Response: a last byte goes from the input register to the response register.
// Stall: while a response is held by rsp_stall, non-last bytes keep
//   flowing; a last byte waits in the input register, and req_stall rises
//   only when that register cannot drain.
// Reset: clears the parse state and the input and response valid flags, and
//   returns the configuration registers to their defaults (general header,
//   id limit 10, target id 0, index 0, relaxed padding).
module opaque_element_table_walker
   import oetw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_data_byte,
   input  logic         req_last_byte,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_blob_ok,
   output logic [2:0]   rsp_error_code,
   output logic         rsp_found,
   output logic [9:0]   rsp_found_offset,
   output logic [10:0]  rsp_found_length,
   output logic [7:0]   rsp_matched_count,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   // configuration
   logic        mode_ff;
   logic [31:0] spec_ff;
   logic [7:0]  ver_ff;
   logic [7:0]  limit_ff;
   logic [7:0]  tgt_id_ff;
   logic [7:0]  tgt_idx_ff;
   logic        strict_ff;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        advance;

   // parse state
   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] cd_ff, cd_in;
   logic [7:0]       elem_ff, elem_in;
   logic [OFF_W-1:0] es_ff, es_in;
   logic             is_tgt_ff, is_tgt_in;
   logic [23:0]      shift_ff, shift_in;
   logic [7:0]       dlen_lo_ff, dlen_lo_in;
   logic [1:0]       pad_ff, pad_in;
   logic [7:0]       match_ff, match_in;
   logic [OFF_W-1:0] hit_off_ff, hit_off_in;
   logic [LEN_W-1:0] hit_len_ff, hit_len_in;
   logic             hit_ff, hit_in;
   err_type          err_ff, err_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        ok_ff, ok_in;
   err_type     code_ff, code_in;
   logic        fnd_ff, fnd_in;
   logic [9:0]  foff_ff, foff_in;
   logic [10:0] flen_ff, flen_in;
   logic [7:0]  mcnt_ff, mcnt_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b1;
         spec_ff    <= SPEC_ID_RESET;
         ver_ff     <= 8'd1;
         limit_ff   <= 8'd10;
         tgt_id_ff  <= 8'd0;
         tgt_idx_ff <= 8'd0;
         strict_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HEADER_MODE: mode_ff    <= csr_wdata[0];
            CSR_SPEC_ID:     spec_ff    <= csr_wdata;
            CSR_VERSION:     ver_ff     <= csr_wdata[7:0];
            CSR_ID_LIMIT:    limit_ff   <= csr_wdata[7:0];
            CSR_TARGET_ID:   tgt_id_ff  <= csr_wdata[7:0];
            CSR_TARGET_IDX:  tgt_idx_ff <= csr_wdata[7:0];
            CSR_STRICT_PAD:  strict_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // A non-last byte never needs the response slot.
   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   always_comb begin
      logic [7:0]       b;
      logic             hdr_err;
      logic [7:0]       cnt;
      logic [POS_W-1:0] last_hdr;
      logic             finish;
      logic [1:0]       pad_sel;
      logic [CNT_W-1:0] cd_dec;
      logic [LEN_W-1:0] elen;
      err_type          res_err;
      logic             res_ok;

      b        = in_byte_ff;
      hdr_err  = 1'b0;
      cnt      = elem_ff;
      last_hdr = mode_ff ? POS_W'(3) : POS_W'(7);
      finish   = 1'b0;
      pad_sel  = pad_ff;
      cd_dec   = cd_ff - CNT_W'(1);
      elen     = LEN_W'(pos_ff) + LEN_W'(1) - LEN_W'(es_ff);
      res_err  = ERR_NONE;
      res_ok   = 1'b0;

      phase_in   = phase_ff;
      pos_in     = pos_ff;
      cd_in      = cd_ff;
      elem_in    = elem_ff;
      es_in      = es_ff;
      is_tgt_in  = is_tgt_ff;
      shift_in   = shift_ff;
      dlen_lo_in = dlen_lo_ff;
      pad_in     = pad_ff;
      match_in   = match_ff;
      hit_off_in = hit_off_ff;
      hit_len_in = hit_len_ff;
      hit_in     = hit_ff;
      err_in     = err_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ok_in   = ok_ff;
      code_in = code_ff;
      fnd_in  = fnd_ff;
      foff_in = foff_ff;
      flen_in = flen_ff;
      mcnt_in = mcnt_ff;

      if (advance) begin
         if (pos_ff >= POS_W'(MAX_BLOB_BYTES)) begin
            err_in = ERR_TOO_LONG;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            if (err_ff == ERR_NONE) begin
               unique case (phase_ff)
                  PH_HDR: begin
                     if (!mode_ff) begin
                        if (pos_ff < POS_W'(4)) shift_in = {b, shift_ff[23:8]};
                        if (pos_ff == POS_W'(3) && {b, shift_ff} != spec_ff) hdr_err = 1'b1;
                        if (pos_ff == POS_W'(4) && b != ver_ff) hdr_err = 1'b1;
                        if (pos_ff == POS_W'(5)) cnt = b;
                     end else if (pos_ff == POS_W'(0)) begin
                        cnt = b;
                     end
                     elem_in = cnt;
                     if (hdr_err) begin
                        err_in = ERR_HEADER;
                     end else if (pos_ff == last_hdr) begin
                        if (cnt == 8'd0) err_in = ERR_HEADER;
                        else phase_in = PH_ID;
                     end
                  end
                  PH_ID: begin
                     if (b > limit_ff) begin
                        err_in = ERR_ID_RANGE;
                     end else begin
                        is_tgt_in = (b == tgt_id_ff);
                        es_in     = pos_ff[OFF_W-1:0];
                        phase_in  = PH_VLEN;
                     end
                  end
                  PH_VLEN: begin
                     cd_in    = CNT_W'(b);
                     phase_in = (b != 8'd0) ? PH_VENDOR : PH_DLEN0;
                  end
                  PH_VENDOR: begin
                     cd_in = cd_dec;
                     if (cd_dec == '0) phase_in = PH_DLEN0;
                  end
                  PH_DLEN0: begin
                     dlen_lo_in = b;
                     phase_in   = PH_DLEN1;
                  end
                  PH_DLEN1: begin
                     // pad up to a 4-byte boundary from the element start
                     pad_sel = 2'd0 - (pos_ff[1:0] + 2'd1 - es_ff[1:0] + dlen_lo_ff[1:0]);
                     pad_in  = pad_sel;
                     if ({b, dlen_lo_ff} != 16'd0) begin
                        cd_in    = CNT_W'({b, dlen_lo_ff});
                        phase_in = PH_DATA;
                     end else if (pad_sel != 2'd0) begin
                        cd_in    = CNT_W'(pad_sel);
                        phase_in = PH_PAD;
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  PH_DATA: begin
                     cd_in = cd_dec;
                     if (cd_dec == '0) begin
                        if (pad_ff != 2'd0) begin
                           cd_in    = CNT_W'(pad_ff);
                           phase_in = PH_PAD;
                        end else begin
                           finish = 1'b1;
                        end
                     end
                  end
                  PH_PAD: begin
                     if (strict_ff && b != 8'd0) begin
                        err_in = ERR_PADDING;
                     end else begin
                        cd_in = cd_dec;
                        if (cd_dec == '0) finish = 1'b1;
                     end
                  end
                  PH_END: begin
                     err_in = ERR_SIZE;
                  end
                  default: begin
                     err_in = ERR_SIZE;
                  end
               endcase

               if (finish) begin
                  if (is_tgt_ff) begin
                     if (match_ff == tgt_idx_ff && !hit_ff) begin
                        hit_off_in = es_ff;
                        hit_len_in = elen;
                        hit_in     = 1'b1;
                     end
                     match_in = match_ff + 8'd1;
                  end
                  elem_in  = elem_ff - 8'd1;
                  phase_in = (elem_ff == 8'd1) ? PH_END : PH_ID;
               end
            end
         end

         if (in_last_ff) begin
            res_err = err_in;
            if (res_err == ERR_NONE) begin
               if (phase_in == PH_HDR) res_err = ERR_HEADER;
               else if (phase_in != PH_END) res_err = ERR_OVERRUN;
            end
            if (res_err != ERR_TOO_LONG && strict_ff && pos_in[1:0] != 2'd0) begin
               res_err = ERR_ALIGN;
            end
            res_ok = (res_err == ERR_NONE);

            rsp_valid_in = 1'b1;
            ok_in   = res_ok;
            code_in = res_err;
            fnd_in  = res_ok && hit_in && (tgt_id_ff <= limit_ff);
            foff_in = fnd_in ? hit_off_in : '0;
            flen_in = fnd_in ? hit_len_in : '0;
            mcnt_in = res_ok ? match_in : 8'd0;

            // drop the blob state for the next blob
            phase_in   = PH_HDR;
            pos_in     = '0;
            cd_in      = '0;
            elem_in    = '0;
            es_in      = '0;
            is_tgt_in  = 1'b0;
            shift_in   = '0;
            dlen_lo_in = '0;
            pad_in     = '0;
            match_in   = '0;
            hit_off_in = '0;
            hit_len_in = '0;
            hit_in     = 1'b0;
            err_in     = ERR_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR;
         pos_ff       <= '0;
         cd_ff        <= '0;
         elem_ff      <= '0;
         es_ff        <= '0;
         is_tgt_ff    <= 1'b0;
         shift_ff     <= '0;
         dlen_lo_ff   <= '0;
         pad_ff       <= '0;
         match_ff     <= '0;
         hit_off_ff   <= '0;
         hit_len_ff   <= '0;
         hit_ff       <= 1'b0;
         err_ff       <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         cd_ff        <= cd_in;
         elem_ff      <= elem_in;
         es_ff        <= es_in;
         is_tgt_ff    <= is_tgt_in;
         shift_ff     <= shift_in;
         dlen_lo_ff   <= dlen_lo_in;
         pad_ff       <= pad_in;
         match_ff     <= match_in;
         hit_off_ff   <= hit_off_in;
         hit_len_ff   <= hit_len_in;
         hit_ff       <= hit_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ok_ff   <= ok_in;
      code_ff <= code_in;
      fnd_ff  <= fnd_in;
      foff_ff <= foff_in;
      flen_ff <= flen_in;
      mcnt_ff <= mcnt_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_blob_ok       = ok_ff;
   assign rsp_error_code    = code_ff;
   assign rsp_found         = fnd_ff;
   assign rsp_found_offset  = foff_ff;
   assign rsp_found_length  = flen_ff;
   assign rsp_matched_count = mcnt_ff;

endmodule

// ===== rtl/core/oetw_checker.sv =====
// Port-level checks of the opaque element table walker and their bind.
`timescale 1ns / 1ps
`include "opaque_element_table_walker_macros.svh"
module oetw_checker
   import oetw_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         req_last_byte,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input logic         rsp_blob_ok,
   input logic [2:0]   rsp_error_code,
   input logic         rsp_found,
   input logic [9:0]   rsp_found_offset,
   input logic [10:0]  rsp_found_length,
   input logic [7:0]   rsp_matched_count
);

   logic last_taken;
   logic rsp_held;

   assign last_taken = req_valid && !req_stall && req_last_byte;
   assign rsp_held   = rsp_valid && rsp_stall;

   // a held response keeps its verdict
   `OETW_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_error_code))

   // a new response only follows a taken last byte, passed through the input register
   `OETW_ASSERT_NOW(a_rsp_cause, $rose(rsp_valid), $past(last_taken, 2))

   // ok and error code agree; a bad blob reports nothing found or counted
   `OETW_ASSERT_NOW(a_ok_code, rsp_valid, rsp_blob_ok == (rsp_error_code == ERR_NONE))
   `OETW_ASSERT_NOW(a_bad_empty, rsp_valid && !rsp_blob_ok, !rsp_found && rsp_matched_count == 8'd0)

   // a miss reports a zero location
   `OETW_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp_found, rsp_found_offset == 10'd0 && rsp_found_length == 11'd0)

endmodule

bind opaque_element_table_walker oetw_checker u_oetw_checker (.*);
